>>> design/uccte_pkg.sv
// Shared types, widths and codes of the unslotted CSMA/CA transmit engine.
package uccte_pkg;

    // Frame queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Item field widths
    localparam int OP_W     = 3;
    localparam int TAG_W    = 8;
    localparam int LEN_W    = 7;
    localparam int DRAW_W   = 8;
    localparam int ACT_W    = 3;
    localparam int COUNT_W  = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Timers
    localparam int BO_REM_W  = 16;
    localparam int IFS_W     = 10;
    localparam int BE_W      = 4;
    localparam int NB_W      = 3;
    localparam int UNIT_W    = 8;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] length;
    } t_frame;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_ENQUEUE   = 3'd1,
        OP_FETCH     = 3'd2,
        OP_CCA       = 3'd3,
        OP_PHY_READY = 3'd4
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_NOTIFY    = 3'd0,
        ACT_CCA_REQ   = 3'd1,
        ACT_TRANSMIT  = 3'd2,
        ACT_SWITCH_RX = 3'd3,
        ACT_DROP_RX   = 3'd4,
        ACT_OVERFLOW  = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_BE      = 3'd0,
        CFG_MAX_BE      = 3'd1,
        CFG_MAX_NB      = 3'd2,
        CFG_UNIT_TICKS  = 3'd3,
        CFG_SHORT_IFS   = 3'd4,
        CFG_LONG_IFS    = 3'd5,
        CFG_SHORT_MAXLN = 3'd6
    } t_cfg_idx;

endpackage

>>> design/uccte_in_if.sv
// Input channel: event items with valid/ready handshake.
interface uccte_in_if import uccte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  frame_tag;
    logic [LEN_W-1:0]  frame_length;
    logic              channel_clear;
    logic [DRAW_W-1:0] random_draw;

    modport source (
        output valid, op, frame_tag, frame_length, channel_clear, random_draw,
        input  ready
    );
    modport sink (
        input  valid, op, frame_tag, frame_length, channel_clear, random_draw,
        output ready
    );
endinterface

>>> design/uccte_out_if.sv
// Output channel: action items with valid/ready handshake.
interface uccte_out_if import uccte_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [TAG_W-1:0]   out_tag;
    logic [LEN_W-1:0]   out_length;
    logic [COUNT_W-1:0] queue_count;

    modport source (
        output valid, action, out_tag, out_length, queue_count,
        input  ready
    );
    modport sink (
        input  valid, action, out_tag, out_length, queue_count,
        output ready
    );
endinterface

>>> design/unslotted_csma_ca_tx_engine.sv
// Top level of the unslotted CSMA/CA transmit engine.
//
// Usage notes:
// - i_item carries events (tick, enqueue, PHY fetch, CCA result, PHY ready);
//   one transfer per clock is taken when valid and ready are both high.
// - o_result carries at most one action per event, in event order.
// - i_cfg_* writes a register at any edge with i_cfg_we high and i_rst_n high; write only
//   while no event is in flight.
// - Throughput: one event per cycle while i_item.ready is high. An event's
//   result is registered in the result stage and then in the output register,
//   and o_result.valid rises once it reaches the output register.
//   The two-entry output path is what lets the block take a new
//   event while a finished result still waits.
// - Frame descriptors sit in an 8-entry synchronous RAM (registered read).
//   A pop reads the head; the popped descriptor is forwarded from the RAM
//   read register for the cycle after the pop, and a same-entry write is
//   bypassed into that register.
// - Reset: control state clears and registers take their defaults; r_listen sets,
//   so the first tick reports a switch to receive. The queue RAM is not cleared.
// - Receiver stall: the output register holds; the result stage absorbs one
//   more result, after which i_item.ready falls until o_result drains.
module unslotted_csma_ca_tx_engine import uccte_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    uccte_in_if.sink              i_item,
    uccte_out_if.source           o_result
);

    // Configuration registers
    logic [BE_W-1:0]   r_min_be, r_max_be;
    logic [NB_W-1:0]   r_max_nb;
    logic [UNIT_W-1:0] r_unit_ticks;
    logic [IFS_W-1:0]  r_short_ifs, r_long_ifs;
    logic [LEN_W-1:0]  r_short_maxlen;

    // Frame queue RAM and its read register
    t_frame r_queue [QUEUE_DEPTH];
    t_frame r_rdata;

    // Control state
    logic [QPTR_W-1:0]  r_head, n_head, r_tail, n_tail;
    logic [QFILL_W-1:0] r_fill, n_fill;
    logic               r_cur_valid, n_cur_valid;
    logic               r_cur_pending;   // current frame still sits in r_rdata
    t_frame             r_current;
    logic               r_txing, n_txing;
    logic [NB_W-1:0]    r_nb, n_nb;
    logic [BE_W-1:0]    r_be, n_be;
    logic [BO_REM_W-1:0] r_bo_rem, n_bo_rem;
    logic               r_bo_run, n_bo_run;
    logic [IFS_W-1:0]   r_ifs_rem, n_ifs_rem;
    logic               r_ifs_run, n_ifs_run;
    logic               r_use_short, n_use_short;
    logic               r_listen, n_listen;

    // Result stage and output register
    logic               r_a_valid, r_a_use_mem;
    t_action            r_a_action;
    t_frame             r_a_frame;
    logic [COUNT_W-1:0] r_a_count;
    logic               r_o_valid;
    t_action            r_o_action;
    t_frame             r_o_frame;
    logic [COUNT_W-1:0] r_o_count;

    // Step signals
    logic          in_fire, a_move;
    t_frame        in_frame, cur;
    logic          push, pop, go_rx, bo_start;
    logic [BE_W-1:0] bo_exp;
    logic [BE_W:0]   be_inc;
    logic [NB_W:0]   nb_inc;
    logic [DRAW_W-1:0] bo_mask;
    logic [BO_REM_W-1:0] bo_product;
    logic          res_valid, res_use_mem;
    t_action       res_action;
    t_frame        res_frame;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] q;
        q = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
        return q;
    endfunction

    // Handshakes: the result stage empties into the output register
    assign a_move         = r_a_valid && (!r_o_valid || o_result.ready);
    assign i_item.ready   = !r_a_valid || a_move;
    assign in_fire        = i_item.valid && i_item.ready;

    assign in_frame = '{tag: i_item.frame_tag, length: i_item.frame_length};
    // Forward the popped descriptor straight from the RAM read register
    assign cur      = r_cur_pending ? r_rdata : r_current;

    // Backoff duration: draw masked to BE bits times the unit period
    always_comb begin
        if (bo_exp >= BE_W'(DRAW_W)) begin
            bo_mask = '1;
        end else begin
            bo_mask = DRAW_W'((BO_REM_W'(1) << bo_exp) - BO_REM_W'(1));
        end
        bo_product = BO_REM_W'(i_item.random_draw & bo_mask) * BO_REM_W'(r_unit_ticks);
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cur_valid = r_cur_valid;
        n_txing     = r_txing;
        n_nb        = r_nb;
        n_be        = r_be;
        n_bo_rem    = r_bo_rem;
        n_bo_run    = r_bo_run;
        n_ifs_rem   = r_ifs_rem;
        n_ifs_run   = r_ifs_run;
        n_use_short = r_use_short;
        n_listen    = r_listen;
        push        = 1'b0;
        pop         = 1'b0;
        go_rx       = 1'b0;
        bo_start    = 1'b0;
        bo_exp      = r_min_be;
        be_inc      = {1'b0, r_be} + (BE_W+1)'(1);
        nb_inc      = {1'b0, r_nb} + (NB_W+1)'(1);
        res_valid   = 1'b0;
        res_use_mem = 1'b0;
        res_action  = ACT_NOTIFY;
        res_frame   = '0;

        if (in_fire) begin
            unique case (t_op'(i_item.op))
                OP_TICK: begin
                    if (r_bo_run && (r_bo_rem != '0)) n_bo_rem = r_bo_rem - BO_REM_W'(1);
                    if (r_ifs_run && (r_ifs_rem != '0)) n_ifs_rem = r_ifs_rem - IFS_W'(1);
                    if (r_listen) begin
                        n_listen   = 1'b0;
                        res_valid  = 1'b1;
                        res_action = ACT_SWITCH_RX;
                    end else if (r_bo_run && (n_bo_rem == '0)) begin
                        n_bo_run   = 1'b0;
                        res_valid  = 1'b1;
                        res_action = ACT_CCA_REQ;
                    end else if (r_ifs_run && (n_ifs_rem == '0)) begin
                        n_ifs_run = 1'b0;
                        if (r_fill != '0) begin
                            pop         = 1'b1;
                            res_valid   = 1'b1;
                            res_action  = ACT_NOTIFY;
                            res_use_mem = 1'b1;
                        end
                    end
                end
                OP_ENQUEUE: begin
                    if (r_fill >= QFILL_W'(QUEUE_DEPTH)) begin
                        res_valid  = 1'b1;
                        res_action = ACT_OVERFLOW;
                        res_frame  = in_frame;
                    end else begin
                        push = 1'b1;
                        if (!r_cur_valid && !r_txing && !r_ifs_run) begin
                            pop         = 1'b1;
                            res_valid   = 1'b1;
                            res_action  = ACT_NOTIFY;
                            res_use_mem = 1'b1;
                        end
                    end
                end
                OP_FETCH: begin
                    if (r_cur_valid && !r_bo_run && !r_ifs_run) begin
                        n_nb     = '0;
                        n_be     = r_min_be;
                        bo_exp   = r_min_be;
                        bo_start = 1'b1;
                    end
                end
                OP_CCA: begin
                    if (i_item.channel_clear) begin
                        if (r_cur_valid) begin
                            n_use_short = (cur.length <= r_short_maxlen);
                            n_cur_valid = 1'b0;
                            n_txing     = 1'b1;
                            res_valid   = 1'b1;
                            res_action  = ACT_TRANSMIT;
                            res_frame   = cur;
                        end
                    end else if (!r_cur_valid) begin
                        go_rx      = 1'b1;
                        res_valid  = 1'b1;
                        res_action = ACT_SWITCH_RX;
                    end else begin
                        // NB saturates at 7; the drop test sees the raw count
                        n_nb   = nb_inc[NB_W] ? '1 : nb_inc[NB_W-1:0];
                        n_be   = (be_inc > {1'b0, r_max_be}) ? r_max_be : be_inc[BE_W-1:0];
                        bo_exp = n_be;
                        if (nb_inc <= {1'b0, r_max_nb}) begin
                            bo_start = 1'b1;
                        end else begin
                            n_use_short = (cur.length <= r_short_maxlen);
                            if (!r_txing) begin
                                go_rx      = 1'b1;
                                res_valid  = 1'b1;
                                res_action = ACT_DROP_RX;
                                res_frame  = cur;
                            end
                        end
                    end
                end
                OP_PHY_READY: begin
                    // Backoff keeps running
                    go_rx      = 1'b1;
                    res_valid  = 1'b1;
                    res_action = ACT_SWITCH_RX;
                end
                default: begin
                end
            endcase
        end

        if (go_rx) begin
            n_cur_valid = 1'b0;
            n_txing     = 1'b0;
            n_ifs_rem   = n_use_short ? r_short_ifs : r_long_ifs;
            n_ifs_run   = 1'b1;
        end
        if (bo_start) begin
            n_bo_rem = bo_product;
            n_bo_run = 1'b1;
        end
        if (pop) begin
            n_cur_valid = 1'b1;
            n_head      = ptr_next(r_head);
        end
        if (push) n_tail = ptr_next(r_tail);
        n_fill = r_fill + QFILL_W'(push) - QFILL_W'(pop);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_be       <= BE_W'(3);
            r_max_be       <= BE_W'(5);
            r_max_nb       <= NB_W'(4);
            r_unit_ticks   <= UNIT_W'(20);
            r_short_ifs    <= IFS_W'(12);
            r_long_ifs     <= IFS_W'(40);
            r_short_maxlen <= LEN_W'(18);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_BE:      r_min_be       <= i_cfg_data[BE_W-1:0];
                CFG_MAX_BE:      r_max_be       <= i_cfg_data[BE_W-1:0];
                CFG_MAX_NB:      r_max_nb       <= i_cfg_data[NB_W-1:0];
                CFG_UNIT_TICKS:  r_unit_ticks   <= i_cfg_data[UNIT_W-1:0];
                CFG_SHORT_IFS:   r_short_ifs    <= i_cfg_data[IFS_W-1:0];
                CFG_LONG_IFS:    r_long_ifs     <= i_cfg_data[IFS_W-1:0];
                CFG_SHORT_MAXLN: r_short_maxlen <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Queue RAM: one write port, one registered read port, write bypass
    always_ff @(posedge i_clk) begin
        if (push) r_queue[r_tail] <= in_frame;
        if (pop) begin
            if (push && (r_tail == r_head)) begin
                r_rdata <= in_frame;
            end else begin
                r_rdata <= r_queue[r_head];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_cur_valid   <= 1'b0;
            r_cur_pending <= 1'b0;
            r_txing       <= 1'b0;
            r_nb          <= '0;
            r_be          <= '0;
            r_bo_rem      <= '0;
            r_bo_run      <= 1'b0;
            r_ifs_rem     <= '0;
            r_ifs_run     <= 1'b0;
            r_use_short   <= 1'b0;
            r_listen      <= 1'b1;
        end else begin
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_fill        <= n_fill;
            r_cur_valid   <= n_cur_valid;
            r_cur_pending <= pop;
            r_txing       <= n_txing;
            r_nb          <= n_nb;
            r_be          <= n_be;
            r_bo_rem      <= n_bo_rem;
            r_bo_run      <= n_bo_run;
            r_ifs_rem     <= n_ifs_rem;
            r_ifs_run     <= n_ifs_run;
            r_use_short   <= n_use_short;
            r_listen      <= n_listen;
        end
    end

    // Current descriptor leaves the read register in the cycle after a pop, when r_current takes it over
    always_ff @(posedge i_clk) begin
        r_current <= cur;
    end

    // Result stage and output register valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_fire && res_valid) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payloads; a notify takes the popped descriptor from the read register
    always_ff @(posedge i_clk) begin
        if (in_fire && res_valid) begin
            r_a_action  <= res_action;
            r_a_frame   <= res_frame;
            r_a_use_mem <= res_use_mem;
            r_a_count   <= COUNT_W'(n_fill);
        end
        if (a_move) begin
            r_o_action <= r_a_action;
            r_o_frame  <= r_a_use_mem ? r_rdata : r_a_frame;
            r_o_count  <= r_a_count;
        end
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.action      = r_o_action;
    assign o_result.out_tag     = r_o_frame.tag;
    assign o_result.out_length  = r_o_frame.length;
    assign o_result.queue_count = r_o_count;

endmodule
